[hw/rtl/assert_macros.svh]
// Assertion helpers; clk and rst_n must be in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SQPI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SQPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SQPI_ASSERT(lbl, expr, msg)
`define SQPI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/sqpi_pkg.sv]
package sqpi_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT
  } cell_cmd_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } queue_ctl_t;

endpackage

[hw/rtl/sqpi_cell.sv]
module sqpi_cell (
  input  logic                          clk,
  input  sqpi_pkg::cell_cmd_t           cmd,
  input  logic [sqpi_pkg::WORD_W-1:0]   prev_word,
  input  logic [sqpi_pkg::WORD_W-1:0]   next_word,
  input  logic [sqpi_pkg::WORD_W-1:0]   load_word,
  output logic [sqpi_pkg::WORD_W-1:0]   word
);

  logic [sqpi_pkg::WORD_W-1:0] word_r;
  logic [sqpi_pkg::WORD_W-1:0] word_nxt;

  always_comb begin
    unique case (cmd)
      sqpi_pkg::CELL_HOLD: word_nxt = word_r;
      sqpi_pkg::CELL_LOAD: word_nxt = load_word;
      sqpi_pkg::CELL_PREV: word_nxt = prev_word;
      sqpi_pkg::CELL_NEXT: word_nxt = next_word;
      default:             word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

[hw/rtl/sqpi_queue.sv]
module sqpi_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  sqpi_pkg::queue_ctl_t          ctl,
  input  logic [CW-1:0]                 at,
  input  logic [sqpi_pkg::WORD_W-1:0]   load_word,
  output logic [sqpi_pkg::WORD_W-1:0]   head_word
);

  logic [sqpi_pkg::WORD_W-1:0] words [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(k);
    sqpi_pkg::cell_cmd_t         cmd;
    logic [sqpi_pkg::WORD_W-1:0] prev_w;
    logic [sqpi_pkg::WORD_W-1:0] next_w;

    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = words[k+1];
    end

    always_comb begin
      priority if (ctl.pop) begin
        cmd = (k == DEPTH - 1) ? sqpi_pkg::CELL_HOLD : sqpi_pkg::CELL_NEXT;
      end else if (ctl.ins && IDX == at) begin
        cmd = sqpi_pkg::CELL_LOAD;
      end else if (ctl.ins && IDX > at) begin
        cmd = sqpi_pkg::CELL_PREV;
      end else begin
        cmd = sqpi_pkg::CELL_HOLD;
      end
    end

    sqpi_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .prev_word (prev_w),
      .next_word (next_w),
      .load_word (load_word),
      .word      (words[k])
    );
  end

  assign head_word = words[0];

endmodule

[hw/rtl/shifting_queue_with_positional_insert.sv]
// Two shift-register queues of DEPTH 64-bit words, head at entry 0.
// Input words (in_*): in_tuser carries the operation (append, insert at
// position, move head to the other queue) and the queue select; in_tdata
// carries the payload and the 1-based insert position.
// Result words (out_*): one per input word, giving status, the moved payload
// and the fill counts of both queues after the operation.
// The result is registered and appears in the cycle after the input word is taken.
// Throughput: one word per cycle unless the receiver stalls; the cells of both
// queues shift, load or hold in the same cycle, so the cell row sets the rate.
// A registered output stage holds the result; while the receiver stalls with
// a result pending, in_tready is low and the queues hold.
// Reset empties both queues (fill counts to zero) and drops any pending
// result; entry contents are not cleared.
`include "assert_macros.svh"
module shifting_queue_with_positional_insert #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // entry_data[63:0], position[68:64], zero pad
  input  logic [2:0]  in_tuser,   // operation[1:0], queue_select[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // status[1:0], moved_data[65:2],
                                  // first_count[70:66], second_count[75:71], pad
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > sqpi_pkg::POS_W) ? CW : sqpi_pkg::POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic                                accept;
  logic [sqpi_pkg::OP_W-1:0]           op;
  logic                                sel;
  logic [sqpi_pkg::WORD_W-1:0]         entry;
  logic [sqpi_pkg::POS_W-1:0]          pos;

  logic [CW-1:0]                       fill_r [2];
  logic [CW-1:0]                       fill_nxt [2];
  sqpi_pkg::queue_ctl_t                ctl [2];
  logic [CW-1:0]                       at [2];
  logic [sqpi_pkg::WORD_W-1:0]         load_w [2];
  logic [sqpi_pkg::WORD_W-1:0]         head_w [2];

  logic [PW-1:0]                       pos_ext;
  logic [PW-1:0]                       at_raw;
  logic [PW-1:0]                       fill_sel_ext;
  logic [CW-1:0]                       ins_at;
  logic [sqpi_pkg::STAT_W-1:0]         status;
  logic [sqpi_pkg::WORD_W-1:0]         moved;
  logic [PW-1:0]                       cnt_ext [2];

  logic                                out_tvalid_r;
  logic [79:0]                         out_tdata_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = in_tuser[1:0];
  assign sel       = in_tuser[2];
  assign entry     = in_tdata[63:0];
  assign pos       = in_tdata[68:64];

  assign pos_ext      = PW'(pos);
  assign at_raw       = (pos == '0) ? '0 : pos_ext - PW'(1);
  assign fill_sel_ext = PW'(fill_r[sel]);
  assign ins_at       = (at_raw > fill_sel_ext) ? fill_r[sel] : at_raw[CW-1:0];

  always_comb begin
    fill_nxt[0] = fill_r[0];
    fill_nxt[1] = fill_r[1];
    ctl[0]      = '0;
    ctl[1]      = '0;
    at[0]       = fill_r[0];
    at[1]       = fill_r[1];
    load_w[0]   = entry;
    load_w[1]   = entry;
    status      = sqpi_pkg::ST_DONE;
    moved       = '0;
    if (accept) begin
      unique case (op)
        sqpi_pkg::OP_APPEND, sqpi_pkg::OP_INSERT: begin
          if (fill_r[sel] == FULL_CNT) begin
            status = sqpi_pkg::ST_FULL;
          end else begin
            ctl[sel].ins  = 1'b1;
            at[sel]       = (op == sqpi_pkg::OP_INSERT) ? ins_at : fill_r[sel];
            fill_nxt[sel] = fill_r[sel] + CW'(1);
          end
        end
        sqpi_pkg::OP_MOVE: begin
          if (fill_r[sel] == '0) begin
            status = sqpi_pkg::ST_EMPTY;
          end else begin
            moved         = head_w[sel];
            ctl[sel].pop  = 1'b1;
            fill_nxt[sel] = fill_r[sel] - CW'(1);
            load_w[!sel]  = head_w[sel];
            if (fill_r[!sel] == FULL_CNT) begin
              status = sqpi_pkg::ST_FULL;
            end else begin
              ctl[!sel].ins  = 1'b1;
              fill_nxt[!sel] = fill_r[!sel] + CW'(1);
            end
          end
        end
        default: begin
          status = sqpi_pkg::ST_DONE;
        end
      endcase
    end
  end

  for (genvar q = 0; q < 2; q++) begin : g_queue
    sqpi_queue #(
      .DEPTH (DEPTH),
      .CW    (CW)
    ) u_queue (
      .clk       (clk),
      .ctl       (ctl[q]),
      .at        (at[q]),
      .load_word (load_w[q]),
      .head_word (head_w[q])
    );
    assign cnt_ext[q] = PW'(fill_nxt[q]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0]    <= '0;
      fill_r[1]    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      fill_r[0] <= fill_nxt[0];
      fill_r[1] <= fill_nxt[1];
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {4'b0, cnt_ext[1][sqpi_pkg::CNT_W-1:0],
                      cnt_ext[0][sqpi_pkg::CNT_W-1:0], moved, status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `SQPI_ASSERT(a_fill_bound, fill_r[0] <= FULL_CNT && fill_r[1] <= FULL_CNT, "fill count above depth")
  `SQPI_ASSERT_NEXT(a_idle_hold, !accept, fill_r[0] == $past(fill_r[0]) && fill_r[1] == $past(fill_r[1]), "fill changed without an accepted word")
  `SQPI_ASSERT_NEXT(a_append_grows, accept && op == sqpi_pkg::OP_APPEND && fill_r[sel] != FULL_CNT, fill_r[$past(sel)] == $past(fill_r[sel]) + CW'(1), "append did not grow the target queue")
  `SQPI_ASSERT(a_empty_zero, !(out_tvalid_r && out_tdata_r[1:0] == sqpi_pkg::ST_EMPTY) || out_tdata_r[65:2] == '0, "empty move reported a payload")

endmodule
